// ----- design/fcc_pkg.sv -----
// Shared codes, constants and types of the FAT16 cluster chain engine.
package fcc_pkg;

    localparam int LINK_W  = 16;
    localparam int COUNT_W = 17;

    typedef enum logic [2:0] {
        OP_WRITE = 3'd0,
        OP_READ  = 3'd1,
        OP_ALLOC = 3'd2,
        OP_FREE  = 3'd3,
        OP_SEEK  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_END  = 2'd1,
        ST_FULL = 2'd2,
        ST_BAD  = 2'd3
    } status_t;

    localparam logic [LINK_W-1:0] FIRST_DATA = 16'h0002;
    localparam logic [LINK_W-1:0] END_MARK   = 16'hFFF8;
    localparam logic [LINK_W-1:0] LAST_LINK  = 16'hFFFF;
    localparam logic [LINK_W-1:0] FREE_LINK  = 16'h0000;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_RDWAIT    = 8'b0000_0010,
        S_SCAN1     = 8'b0000_0100,
        S_SCAN2     = 8'b0000_1000,
        S_ALLOC_END = 8'b0001_0000,
        S_WALK      = 8'b0010_0000,
        S_FREE      = 8'b0100_0000,
        S_DONE      = 8'b1000_0000
    } state_t;

endpackage

// ----- design/fat16_cluster_chain_engine.sv -----
// FAT16 cluster chain engine: link table, allocate, free, seek and entry access.
//
// Channel  | Dir | Handshake          | Payload
// ---------+-----+--------------------+---------------------------------------------
// s_*      | in  | s_tvalid/s_tready  | tuser: operation; tdata: index, value, first,
//          |     |                    |   count, position
// m_*      | out | m_tvalid/m_tready  | tdata: status, cluster, clusters_walked
// cfg_*    | in  | cfg_valid/cfg_ready| table_entries (always ready)
//
// Allocate scans the table one entry per cycle through the single memory read port,
// twice (count, then link), and reports disk full if too few entries are free.
// Seek walks the chain to the chain position; free walks it one link per cycle checking,
// then one per cycle clearing.
// rst_n clears the sequencer and sets table_entries to 65536; the table is not cleared.
// A new request is taken while a result waits on m_*; the next result waits for it.
module fat16_cluster_chain_engine #(
    parameter int MAX_ENTRIES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] operation
    input  logic [2:0]  s_tuser,
    // [15:0] entry_index, [31:16] entry_value, [47:32] first_cluster,
    // [63:48] cluster_count, [79:64] chain_position
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [17:2] cluster, [34:18] clusters_walked, [39:35] zero
    output logic [39:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam logic [16:0] MAX_N = 17'(MAX_ENTRIES);

    logic [15:0] link_mem [MAX_ENTRIES];
    logic [15:0] rd_data_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    fcc_pkg::state_t state_reg, state_next;
    logic [16:0] tent_reg;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [39:0] m_tdata_reg, m_tdata_next;

    logic        pend_reg, pend_next;
    logic        use_rd_reg, use_rd_next;
    logic        seek_reg, seek_next;
    logic [15:0] found_reg, found_next;
    logic [16:0] k_reg, k_next;
    logic [16:0] rem_reg, rem_next;
    logic [16:0] scan_reg, scan_next;
    logic [16:0] chk_reg, chk_next;

    logic [15:0] first_reg, first_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] cur_reg, cur_next;
    logic [15:0] prev_reg, prev_next;

    fcc_pkg::status_t res_status_reg, res_status_next;
    logic [15:0] res_cluster_reg, res_cluster_next;
    logic [16:0] res_walked_reg, res_walked_next;

    logic [16:0] n_w;
    logic [16:0] lim_w;
    logic [15:0] cur_w;
    logic        in_chain_w;
    logic [15:0] in_idx;
    logic [15:0] in_val;
    logic [15:0] in_first;
    logic [15:0] in_count;
    logic [15:0] in_pos;
    logic [15:0] first_pick;

    assign s_tready  = (state_reg == fcc_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign n_w   = (tent_reg > MAX_N) ? MAX_N : tent_reg;
    assign lim_w = n_w - 17'd2;
    assign cur_w = use_rd_reg ? rd_data_reg : cur_reg;
    assign in_chain_w = (cur_w >= fcc_pkg::FIRST_DATA) && (cur_w < fcc_pkg::END_MARK);

    assign in_idx   = s_tdata[15:0];
    assign in_val   = s_tdata[31:16];
    assign in_first = s_tdata[47:32];
    assign in_count = s_tdata[63:48];
    assign in_pos   = s_tdata[79:64];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= link_mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        pend_next        = pend_reg;
        use_rd_next      = use_rd_reg;
        seek_next        = seek_reg;
        found_next       = found_reg;
        k_next           = k_reg;
        rem_next         = rem_reg;
        scan_next        = scan_reg;
        chk_next         = chk_reg;
        first_next       = first_reg;
        count_next       = count_reg;
        pos_next         = pos_reg;
        cur_next         = cur_reg;
        prev_next        = prev_reg;
        res_status_next  = res_status_reg;
        res_cluster_next = res_cluster_reg;
        res_walked_next  = res_walked_reg;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = '0;
        mem_re           = 1'b0;
        mem_raddr        = '0;
        first_pick       = first_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg) inside
            fcc_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_status_next  = fcc_pkg::ST_OK;
                    res_cluster_next = '0;
                    res_walked_next  = '0;
                    state_next       = fcc_pkg::S_DONE;
                    unique case (s_tuser) inside
                        fcc_pkg::OP_WRITE:
                        begin
                            if ({1'b0, in_idx} < n_w)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = in_idx[AW-1:0];
                                mem_wdata = in_val;
                            end
                            else
                            begin
                                res_status_next = fcc_pkg::ST_BAD;
                            end
                        end
                        fcc_pkg::OP_READ:
                        begin
                            if ({1'b0, in_idx} < n_w)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = in_idx[AW-1:0];
                                state_next = fcc_pkg::S_RDWAIT;
                            end
                            else
                            begin
                                res_status_next = fcc_pkg::ST_BAD;
                            end
                        end
                        fcc_pkg::OP_ALLOC:
                        begin
                            if (in_count != 16'd0)
                            begin
                                count_next = in_count;
                                scan_next  = {1'b0, fcc_pkg::FIRST_DATA};
                                pend_next  = 1'b0;
                                found_next = '0;
                                state_next = fcc_pkg::S_SCAN1;
                            end
                        end
                        fcc_pkg::OP_FREE, fcc_pkg::OP_SEEK:
                        begin
                            first_next  = in_first;
                            cur_next    = in_first;
                            pos_next    = in_pos;
                            use_rd_next = 1'b0;
                            k_next      = '0;
                            seek_next   = (s_tuser == fcc_pkg::OP_SEEK);
                            state_next  = fcc_pkg::S_WALK;
                        end
                        default:
                        begin
                            // unknown operation: plain ok result
                        end
                    endcase
                end
            end

            fcc_pkg::S_RDWAIT:
            begin
                res_cluster_next = rd_data_reg;
                state_next       = fcc_pkg::S_DONE;
            end

            fcc_pkg::S_SCAN1, fcc_pkg::S_SCAN2:
            begin
                // read one entry ahead, judge the one read last cycle
                mem_re    = 1'b1;
                mem_raddr = scan_reg[AW-1:0];
                scan_next = scan_reg + 17'd1;
                chk_next  = scan_reg;
                pend_next = 1'b1;
                if (pend_reg)
                begin
                    if (state_reg == fcc_pkg::S_SCAN1)
                    begin
                        if (chk_reg >= n_w)
                        begin
                            res_status_next  = fcc_pkg::ST_FULL;
                            res_cluster_next = '0;
                            res_walked_next  = '0;
                            state_next       = fcc_pkg::S_DONE;
                        end
                        else if (rd_data_reg == fcc_pkg::FREE_LINK)
                        begin
                            if (found_reg == 16'd0)
                            begin
                                first_pick = chk_reg[15:0];
                            end
                            first_next = first_pick;
                            found_next = found_reg + 16'd1;
                            if (({1'b0, found_reg} + 17'd1) == {1'b0, count_reg})
                            begin
                                // enough free entries: restart at the first one and link
                                scan_next  = {1'b0, first_pick};
                                pend_next  = 1'b0;
                                found_next = '0;
                                state_next = fcc_pkg::S_SCAN2;
                            end
                        end
                    end
                    else if ((chk_reg < n_w) && (rd_data_reg == fcc_pkg::FREE_LINK))
                    begin
                        if (found_reg != 16'd0)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = prev_reg[AW-1:0];
                            mem_wdata = chk_reg[15:0];
                        end
                        prev_next  = chk_reg[15:0];
                        found_next = found_reg + 16'd1;
                        if (({1'b0, found_reg} + 17'd1) == {1'b0, count_reg})
                        begin
                            state_next = fcc_pkg::S_ALLOC_END;
                        end
                    end
                end
            end

            fcc_pkg::S_ALLOC_END:
            begin
                mem_we           = 1'b1;
                mem_waddr        = prev_reg[AW-1:0];
                mem_wdata        = fcc_pkg::LAST_LINK;
                res_status_next  = fcc_pkg::ST_OK;
                res_cluster_next = first_reg;
                res_walked_next  = {1'b0, count_reg};
                state_next       = fcc_pkg::S_DONE;
            end

            fcc_pkg::S_WALK:
            begin
                cur_next = cur_w;
                if (!in_chain_w)
                begin
                    if (seek_reg)
                    begin
                        res_status_next  = fcc_pkg::ST_END;
                        res_cluster_next = '0;
                        res_walked_next  = k_reg;
                        state_next       = fcc_pkg::S_DONE;
                    end
                    else
                    begin
                        // chain checked: clear it from the start
                        rem_next    = k_reg;
                        cur_next    = first_reg;
                        use_rd_next = 1'b0;
                        state_next  = fcc_pkg::S_FREE;
                    end
                end
                else if (({1'b0, cur_w} >= n_w) || (k_reg >= lim_w))
                begin
                    res_status_next  = fcc_pkg::ST_BAD;
                    res_cluster_next = cur_w;
                    res_walked_next  = k_reg;
                    state_next       = fcc_pkg::S_DONE;
                end
                else if (seek_reg && (k_reg == {1'b0, pos_reg}))
                begin
                    res_status_next  = fcc_pkg::ST_OK;
                    res_cluster_next = cur_w;
                    res_walked_next  = k_reg;
                    state_next       = fcc_pkg::S_DONE;
                end
                else
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = cur_w[AW-1:0];
                    use_rd_next = 1'b1;
                    k_next      = k_reg + 17'd1;
                end
            end

            fcc_pkg::S_FREE:
            begin
                if (use_rd_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cur_reg[AW-1:0];
                    mem_wdata = fcc_pkg::FREE_LINK;
                end
                if (rem_reg != 17'd0)
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = cur_w[AW-1:0];
                    cur_next    = cur_w;
                    rem_next    = rem_reg - 17'd1;
                    use_rd_next = 1'b1;
                end
                else
                begin
                    use_rd_next      = 1'b0;
                    res_status_next  = fcc_pkg::ST_OK;
                    res_cluster_next = '0;
                    res_walked_next  = k_reg;
                    state_next       = fcc_pkg::S_DONE;
                end
            end

            fcc_pkg::S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, res_walked_reg, res_cluster_reg, res_status_reg};
                    state_next    = fcc_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = fcc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= fcc_pkg::S_IDLE;
            tent_reg     <= 17'h10000;
            m_tvalid_reg <= 1'b0;
            pend_reg     <= 1'b0;
            use_rd_reg   <= 1'b0;
            seek_reg     <= 1'b0;
            found_reg    <= '0;
            k_reg        <= '0;
            rem_reg      <= '0;
            scan_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            pend_reg     <= pend_next;
            use_rd_reg   <= use_rd_next;
            seek_reg     <= seek_next;
            found_reg    <= found_next;
            k_reg        <= k_next;
            rem_reg      <= rem_next;
            scan_reg     <= scan_next;
            if (cfg_valid && cfg_ready)
            begin
                tent_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg     <= m_tdata_next;
        chk_reg         <= chk_next;
        first_reg       <= first_next;
        count_reg       <= count_next;
        pos_reg         <= pos_next;
        cur_reg         <= cur_next;
        prev_reg        <= prev_next;
        res_status_reg  <= res_status_next;
        res_cluster_reg <= res_cluster_next;
        res_walked_reg  <= res_walked_next;
    end

`ifndef SYNTH
    a_port_conflict: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("table written and read at the same entry");

    a_link_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fcc_pkg::S_SCAN2) |-> (found_reg < count_reg))
        else $error("link pass ran past the requested count");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == fcc_pkg::S_DONE) && (!m_tvalid_reg || m_tready)) |=>
        (m_tvalid_reg && (state_reg == fcc_pkg::S_IDLE)))
        else $error("result not presented after completion");

    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == fcc_pkg::S_DONE) && (res_status_reg == fcc_pkg::ST_FULL)) |->
        ((res_cluster_reg == 16'd0) && (res_walked_reg == 17'd0)))
        else $error("disk full result carries data");
`endif

endmodule
